>>> hdl/sss_pkg.sv
`default_nettype none

package sss_pkg;

	// field widths
	localparam int RSSI_W = 8;
	localparam int TAG_W  = 8;
	localparam int QUAL_W = 7;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture an accepted beat
		logic insert;     // insert captured entry into the sorted chain
		logic shift_out;  // emit the head cell and shift the chain up
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last_pend;  // captured entry carries the last mark
		logic one_left;   // exactly one entry remains in the chain
	} dp_status_t;

endpackage

`default_nettype wire

>>> hdl/sss_ctrl.sv
`default_nettype none

module sss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire sss_pkg::dp_status_t status,
	output logic                     busy,
	output sss_pkg::ctrl_cmd_t       cmd
);
	import sss_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_INSERT = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	// new beats are taken while idle or inserting, unless the list is closing
	assign busy   = (state_q == ST_EMIT) || ((state_q == ST_INSERT) && status.last_pend);
	assign accept = start && !busy;

	assign cmd.load      = accept;
	assign cmd.insert    = (state_q == ST_INSERT);
	assign cmd.shift_out = (state_q == ST_EMIT);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_nxt = ST_INSERT;
			end
			ST_INSERT: begin
				if (status.last_pend)
					state_nxt = ST_EMIT;
				else if (accept)
					state_nxt = ST_INSERT;
				else
					state_nxt = ST_IDLE;
			end
			ST_EMIT: begin
				if (status.one_left)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

`default_nettype wire

>>> hdl/sss_dp.sv
`default_nettype none

module sss_dp #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire sss_pkg::ctrl_cmd_t                      cmd,
	output sss_pkg::dp_status_t                          status,
	input  wire logic                                    cfg_we,
	input  wire logic [sss_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [sss_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  wire logic signed [sss_pkg::RSSI_W-1:0]       rssi_dbm,
	input  wire logic [sss_pkg::TAG_W-1:0]               entry_tag,
	input  wire logic                                    last_entry,
	output logic                                         result_strobe,
	output logic [sss_pkg::TAG_W-1:0]                    sorted_tag,
	output logic [sss_pkg::QUAL_W-1:0]                   quality,
	output logic                                         last_result
);
	import sss_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [QUAL_W-1:0] QUAL_TOP = QUAL_W'(100);

	// thresholds
	logic signed [RSSI_W-1:0] floor_q;
	logic signed [RSSI_W-1:0] ceiling_q;

	// captured entry
	logic [QUAL_W-1:0] qual_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              last_s1;

	// sorted chain, descending quality, stable
	logic [QUAL_W-1:0] cell_qual_q [MAX_ENTRIES];
	logic [TAG_W-1:0]  cell_tag_q  [MAX_ENTRIES];
	logic [CNT_W-1:0]  count_q;
	logic [MAX_ENTRIES-1:0] keep;
	logic [MAX_ENTRIES-1:0] prev_keep;
	logic full;

	// output beat
	logic              strobe_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [QUAL_W-1:0] out_qual_q;
	logic              out_last_q;

	// strength to quality
	logic signed [RSSI_W+1:0] dbm_ext;
	logic signed [RSSI_W+1:0] scaled;
	logic [QUAL_W-1:0]        qual_new;

	assign dbm_ext = {{2{rssi_dbm[RSSI_W-1]}}, rssi_dbm};
	assign scaled  = (dbm_ext + (RSSI_W+2)'(100)) <<< 1;

	always_comb begin
		if (rssi_dbm <= floor_q)
			qual_new = '0;
		else if (rssi_dbm >= ceiling_q)
			qual_new = QUAL_TOP;
		else if (scaled < 0)
			qual_new = '0;
		else if (scaled > (RSSI_W+2)'(100))
			qual_new = QUAL_TOP;
		else
			qual_new = scaled[QUAL_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= -8'sd100;
			ceiling_q <= -8'sd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLOOR:   floor_q   <= cfg_data;
				CFG_CEILING: ceiling_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_s1 <= 1'b0;
		else if (cmd.load)
			last_s1 <= last_entry;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qual_s1 <= qual_new;
			tag_s1  <= entry_tag;
		end
	end

	assign full      = (count_q == CNT_W'(MAX_ENTRIES));
	assign prev_keep = {keep[MAX_ENTRIES-2:0], 1'b1};

	// chain cells: keep, take the new entry, shift down one place, or shift up on emit
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [QUAL_W-1:0] up_qual;
		logic [TAG_W-1:0]  up_tag;
		logic [QUAL_W-1:0] dn_qual;
		logic [TAG_W-1:0]  dn_tag;

		assign keep[i] = (count_q > CNT_W'(i)) && (cell_qual_q[i] >= qual_s1);

		if (i == 0) begin : g_head
			assign up_qual = qual_s1;
			assign up_tag  = tag_s1;
		end else begin : g_body
			assign up_qual = cell_qual_q[i-1];
			assign up_tag  = cell_tag_q[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign dn_qual = cell_qual_q[i];
			assign dn_tag  = cell_tag_q[i];
		end else begin : g_inner
			assign dn_qual = cell_qual_q[i+1];
			assign dn_tag  = cell_tag_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert && !full && !keep[i]) begin
				if (prev_keep[i]) begin
					cell_qual_q[i] <= qual_s1;
					cell_tag_q[i]  <= tag_s1;
				end else begin
					cell_qual_q[i] <= up_qual;
					cell_tag_q[i]  <= up_tag;
				end
			end else if (cmd.shift_out) begin
				cell_qual_q[i] <= dn_qual;
				cell_tag_q[i]  <= dn_tag;
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.insert && !full)
			count_q <= count_q + CNT_W'(1);
		else if (cmd.shift_out)
			count_q <= count_q - CNT_W'(1);
	end

	assign status.last_pend = last_s1;
	assign status.one_left  = (count_q == CNT_W'(1));

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.shift_out;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_out) begin
			out_tag_q  <= cell_tag_q[0];
			out_qual_q <= cell_qual_q[0];
			out_last_q <= (count_q == CNT_W'(1));
		end
	end

	assign result_strobe = strobe_q;
	assign sorted_tag    = out_tag_q;
	assign quality       = out_qual_q;
	assign last_result   = out_last_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && out_last_q |-> count_q == '0)
		else $error("chain not empty after last result");

	a_emit_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !out_last_q |=> strobe_q)
		else $error("gap inside sorted burst");

endmodule

`default_nettype wire

>>> hdl/signal_strength_sorter.sv
`default_nettype none
// Sequence: a beat marked last is inserted in the cycle after it is taken; its first result
//   comes from the EMIT state through the result beat register, then one per cycle.
// Throughput: one unmarked beat per cycle unless busy; the sorted chain inserts in one step.
//   After a marked beat, busy stays high while it is inserted and the stored entries are emitted.
// Reset: arst_n clears control, count and thresholds (-100 / -50 dBm) at once.
// The receiver cannot stall: each result is shown for one cycle under result_strobe.

module signal_strength_sorter #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [sss_pkg::RSSI_W-1:0]    rssi_dbm,
	input  wire logic [sss_pkg::TAG_W-1:0]            entry_tag,
	input  wire logic                                 last_entry,
	output logic                                      result_strobe,
	output logic [sss_pkg::TAG_W-1:0]                 sorted_tag,
	output logic [sss_pkg::QUAL_W-1:0]                quality,
	output logic                                      last_result,
	input  wire logic                                 cfg_we,
	input  wire logic [sss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sss_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import sss_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer
	sss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// conversion, sorted chain and result beat
	sss_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rssi_dbm      (rssi_dbm),
		.entry_tag     (entry_tag),
		.last_entry    (last_entry),
		.result_strobe (result_strobe),
		.sorted_tag    (sorted_tag),
		.quality       (quality),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

>>> sim/signal_strength_sorter_tb.sv
module signal_strength_sorter_tb;

	import sss_pkg::*;

	localparam int MAX_ENTRIES = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 24;

	// one emitted beat: tag, quality, end-of-list mark
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [QUAL_W-1:0] q;
		logic              last;
	} sorted_beat_t;

	// directed stimulus row; typed rows carry their own expected quality
	typedef struct packed {
		int               dbm;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             typed;
		int               q;
	} scan_row_t;

	logic                     clk;
	logic                     arst_n        = 1'b0;
	logic                     start         = 1'b0;
	logic signed [RSSI_W-1:0] rssi_dbm      = '0;
	logic [TAG_W-1:0]         entry_tag     = '0;
	logic                     last_entry    = 1'b0;
	logic                     cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index     = CFG_FLOOR;
	logic [CFG_DATA_W-1:0]    cfg_data      = '0;
	logic                     busy;
	logic                     result_strobe;
	logic [TAG_W-1:0]         sorted_tag;
	logic [QUAL_W-1:0]        quality;
	logic                     last_result;

	// predictor state
	logic signed [RSSI_W-1:0] floor_dbm   = -8'sd100;
	logic signed [RSSI_W-1:0] ceiling_dbm = -8'sd50;
	sorted_beat_t             held_entries[$];
	sorted_beat_t             sorted_beats_due[$];

	int gap_pct      = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	// reset thresholds: floor -100, ceiling -50
	scan_row_t scan_table [21] = '{
		'{-128, 8'h00, 1'b1, 1'b1, 0},    // weakest input
		'{   0, 8'hFF, 1'b1, 1'b1, 100},  // strongest input
		'{-100, 8'hAA, 1'b1, 1'b1, 0},    // exactly at floor
		'{ -99, 8'h55, 1'b1, 1'b1, 2},    // just above floor
		'{ -50, 8'h0F, 1'b1, 1'b1, 100},  // exactly at ceiling
		'{ -51, 8'hF0, 1'b1, 1'b1, 98},   // just below ceiling
		'{ -75, 8'h01, 1'b1, 1'b1, 50},
		// mixed list with ties at 0, 80 and 100
		'{ -60, 8'h10, 1'b0, 1'b0, 0},
		'{ -80, 8'h11, 1'b0, 1'b0, 0},
		'{ -60, 8'h12, 1'b0, 1'b0, 0},
		'{ -20, 8'h13, 1'b0, 1'b0, 0},
		'{-128, 8'h14, 1'b0, 1'b0, 0},
		'{   0, 8'h15, 1'b0, 1'b0, 0},
		'{-100, 8'h16, 1'b1, 1'b0, 0},
		// arrives ascending, must come out reversed
		'{ -99, 8'h20, 1'b0, 1'b0, 0},
		'{ -90, 8'h21, 1'b0, 1'b0, 0},
		'{ -70, 8'h22, 1'b0, 1'b0, 0},
		'{ -55, 8'h23, 1'b1, 1'b0, 0},
		// all saturated, arrival order kept
		'{  -1, 8'h30, 1'b0, 1'b0, 0},
		'{  -2, 8'h31, 1'b0, 1'b0, 0},
		'{  -3, 8'h32, 1'b1, 1'b0, 0}
	};

	int phase_floor [PHASES] = '{-100, -128,    0, -90, 127, -75};
	int phase_ceil  [PHASES] = '{ -50,    0, -128, -60,   5, -75};
	int phase_gap   [PHASES] = '{   0,   60,    0,  27,   0,  60};

	signal_strength_sorter #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.rssi_dbm     (rssi_dbm),
		.entry_tag    (entry_tag),
		.last_entry   (last_entry),
		.result_strobe(result_strobe),
		.sorted_tag   (sorted_tag),
		.quality      (quality),
		.last_result  (last_result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// dBm to quality; floor test first so it wins over the ceiling
	function automatic logic [QUAL_W-1:0] strength_to_quality(logic signed [RSSI_W-1:0] dbm);
		int d;
		int q;
		d = dbm;
		if (d <= int'(floor_dbm))
			return 7'd0;
		if (d >= int'(ceiling_dbm))
			return 7'd100;
		q = 2 * (d + 100);
		if (q < 0)
			q = 0;
		if (q > 100)
			q = 100;
		return 7'(q);
	endfunction

	// store an entry (unless full); on the last mark queue the stable descending order
	function automatic void rank_entry(logic signed [RSSI_W-1:0] dbm, logic [TAG_W-1:0] id,
			logic mark);
		sorted_beat_t run[$];
		sorted_beat_t b;
		int j;
		if (held_entries.size() < MAX_ENTRIES) begin
			b.tag  = id;
			b.q    = strength_to_quality(dbm);
			b.last = 1'b0;
			held_entries.push_back(b);
		end
		if (mark) begin
			foreach (held_entries[i]) begin
				j = 0;
				while (j < run.size() && run[j].q >= held_entries[i].q)
					j++;
				run.insert(j, held_entries[i]);
			end
			run[run.size()-1].last = 1'b1;
			foreach (run[i])
				sorted_beats_due.push_back(run[i]);
			held_entries.delete();
		end
	endfunction

	// offer one beat after a random gap, hold until taken, then predict
	task automatic send_entry(input logic signed [RSSI_W-1:0] dbm, input logic [TAG_W-1:0] id,
			input logic mark, input logic typed, input logic [QUAL_W-1:0] typed_q);
		int n0;
		sorted_beat_t b;
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		rssi_dbm   <= dbm;
		entry_tag  <= id;
		last_entry <= mark;
		do @(posedge clk); while (busy);
		n0 = sorted_beats_due.size();
		rank_entry(dbm, id, mark);
		if (typed) begin
			// single-entry list: the expectation is written in the table
			while (sorted_beats_due.size() > n0)
				void'(sorted_beats_due.pop_back());
			b.tag  = id;
			b.q    = typed_q;
			b.last = 1'b1;
			sorted_beats_due.push_back(b);
		end
	endtask

	// threshold update, only once the sorter has drained
	task automatic set_thresholds(input int fl, input int cl);
		start <= 1'b0;
		while (sorted_beats_due.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FLOOR;
		cfg_data  <= 8'(fl);
		@(posedge clk);
		floor_dbm  = 8'(fl);
		cfg_index <= CFG_CEILING;
		cfg_data  <= 8'(cl);
		@(posedge clk);
		ceiling_dbm = 8'(cl);
		cfg_we     <= 1'b0;
	endtask

	// random scan lists; mostly short, some long enough to overflow the store
	task automatic run_lists(input int budget, input bit force_long);
		int sent;
		int len;
		int v;
		bit first;
		sent  = 0;
		first = force_long;
		while (sent < budget) begin
			if (first)
				len = MAX_ENTRIES + 2;
			else if ($urandom_range(0, 7) == 0)
				len = $urandom_range(28, 40);
			else
				len = $urandom_range(1, 8);
			first = 1'b0;
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					// aim at the thresholds and at -128 and 0
					case ($urandom_range(0, 5))
						0: v = floor_dbm;
						1: v = int'(floor_dbm) + 1;
						2: v = int'(ceiling_dbm) - 1;
						3: v = ceiling_dbm;
						4: v = -128;
						default: v = 0;
					endcase
					if (v < -128)
						v = -128;
					if (v > 0)
						v = 0;
				end else begin
					v = -int'($urandom_range(0, 128));
				end
				send_entry(8'(v), 8'($urandom_range(0, 255)), k == len - 1, 1'b0, 7'd0);
			end
			sent += len;
		end
	endtask

	// stimulus
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (scan_table[i])
			send_entry(8'(scan_table[i].dbm), scan_table[i].tag, scan_table[i].last,
				scan_table[i].typed, 7'(scan_table[i].q));

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				set_thresholds(phase_floor[p], phase_ceil[p]);
			gap_pct = phase_gap[p];
			run_lists(PHASE_ITEMS, p == 0);
		end

		start <= 1'b0;
		while (sorted_beats_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("signal_strength_sorter test passed");
		else
			$display("signal_strength_sorter test failed");
		$finish;
	end

	// result checker
	always @(posedge clk) begin
		sorted_beat_t e;
		if (arst_n && result_strobe) begin
			if (sorted_beats_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat tag=%0h quality=%0d last=%0b",
					$time, sorted_tag, quality, last_result);
			end else begin
				e = sorted_beats_due.pop_front();
				if (sorted_tag !== e.tag) begin
					mismatches++;
					$display("%0t: sorted_tag expected %0h got %0h", $time, e.tag, sorted_tag);
				end
				if (quality !== e.q) begin
					mismatches++;
					$display("%0t: quality expected %0d got %0d", $time, e.q, quality);
				end
				if (last_result !== e.last) begin
					mismatches++;
					$display("%0t: last_result expected %0b got %0b", $time, e.last,
						last_result);
				end
			end
		end
	end

	// watchdog: too long without a beat in or out
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("signal_strength_sorter test failed");
				$finish;
			end
		end
	end

endmodule
